// File: hdl/irs_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and GF(2^8) helper functions for the interleaved
// reed-solomon encoder; no dependencies

package irs_pkg;

  localparam int SYM_BITS   = 8;
  localparam int MAX_PARITY = 32;
  localparam int MAX_DEPTH  = 8;
  localparam int GF_ORDER   = 2**SYM_BITS - 1;

  localparam int OFF_W   = $clog2(MAX_PARITY);
  localparam int ROW_W   = $clog2(MAX_DEPTH);
  localparam int PAR_W   = $clog2(MAX_PARITY + 1);
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int BIT_W   = $clog2(SYM_BITS);
  localparam int POLY_W  = SYM_BITS + 1;
  localparam int LEN_W   = SYM_BITS;

  localparam int NUM_REGS   = 7;
  localparam int APB_ADDR_W = $clog2(NUM_REGS * 4);
  localparam int APB_DATA_W = 32;
  localparam int IDX_W      = APB_ADDR_W - 2;

  localparam int MIN_CODE_LEN = 3;
  localparam int MIN_PARITY   = 2;

  typedef logic [SYM_BITS-1:0] sym_t;
  typedef logic [MAX_PARITY-1:0][SYM_BITS-1:0] par_vec_t;

  // register map, index = byte address / 4
  typedef enum logic [IDX_W-1:0] {
    REG_FIELD_POLY = 3'd0,
    REG_CODE_LEN   = 3'd1,
    REG_PARITY_LEN = 3'd2,
    REG_FIRST_ROOT = 3'd3,
    REG_ROOT_STEP  = 3'd4,
    REG_DEPTH      = 3'd5,
    REG_DUAL_BASIS = 3'd6
  } irs_reg_t;

  // generator polynomial sequencer states
  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_MUL,
    GEN_POW,
    GEN_ACC
  } gen_state_t;

  // settings the generator sequencer works from
  typedef struct packed {
    sym_t             poly;
    sym_t             first_root;
    sym_t             root_step;
    logic [PAR_W-1:0] eff_p;
  } gen_cfg_t;

  // register reset values
  localparam logic [POLY_W-1:0]  RST_FIELD_POLY = 9'd391;
  localparam logic [LEN_W-1:0]   RST_CODE_LEN   = 8'd255;
  localparam logic [PAR_W-1:0]   RST_PARITY_LEN = 6'd32;
  localparam logic [LEN_W-1:0]   RST_FIRST_ROOT = 8'd112;
  localparam logic [LEN_W-1:0]   RST_ROOT_STEP  = 8'd11;
  localparam logic [DEPTH_W-1:0] RST_DEPTH      = 4'd1;
  localparam logic               RST_DUAL_BASIS = 1'b0;

  localparam sym_t ALPHA = 8'h02;

  // conventional to dual basis rows, entry 0 first
  localparam logic [SYM_BITS-1:0][SYM_BITS-1:0] TAL_ROWS =
    {8'h7b, 8'haf, 8'h99, 8'hfa, 8'h86, 8'hec, 8'hef, 8'h8d};

  // multiply modulo x^8 + poly (x^8 term implied)
  function automatic sym_t gf_mul(input sym_t a, input sym_t b, input sym_t poly);
    logic [SYM_BITS:0] x;
    sym_t r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < SYM_BITS; i++) begin
      if (b[i]) r = r ^ x[SYM_BITS-1:0];
      x = {x[SYM_BITS-1:0], 1'b0};
      if (x[SYM_BITS]) x = x ^ {1'b1, poly};
    end
    return r;
  endfunction

  // linear map into the dual basis
  function automatic sym_t conv_to_dual(input sym_t v);
    sym_t r;
    r = '0;
    for (int k = 0; k < SYM_BITS; k++) begin
      if (v[k]) r = r ^ TAL_ROWS[SYM_BITS-1-k];
    end
    return r;
  endfunction

  // inverse map as a lookup table; lowest preimage wins, no preimage gives 0
  function automatic logic [GF_ORDER:0][SYM_BITS-1:0] build_d2c();
    logic [GF_ORDER:0][SYM_BITS-1:0] tab;
    tab = '0;
    for (int i = GF_ORDER; i >= 0; i--) begin
      tab[conv_to_dual(sym_t'(i))] = sym_t'(i);
    end
    return tab;
  endfunction

  localparam logic [GF_ORDER:0][SYM_BITS-1:0] D2C_TAB = build_d2c();

endpackage

// File: hdl/interleaved_rs_encoder_core.sv
`timescale 1ns / 1ps
// interleaved reed-solomon encoder top level: apb registers, request pipeline, row remainders
// depends on irs_pkg and irs_genpoly
// a request is taken into the input register, then into the result register once that is
// empty or being read; throughput: one request per cycle while the output, a rebuild or a
// register write does not stall it; one 32-lane parity row update per message symbol; after
// reset or a register write the generator polynomial is rebuilt one root per pass for p
// roots, p being the effective parity length (at most 32); in_ready is low while it runs
// reset clears the registers to their defaults, all remainders, counters and both stages

module interleaved_rs_encoder_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [irs_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [irs_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [irs_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cmd,
  input  logic [irs_pkg::SYM_BITS-1:0]     symbol,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [irs_pkg::SYM_BITS-1:0]     out_symbol,
  output logic                             is_parity,
  output logic                             last,
  output logic                             error
);
  import irs_pkg::*;

  // configuration registers
  logic [POLY_W-1:0]  field_poly;
  logic [LEN_W-1:0]   code_len;
  logic [PAR_W-1:0]   parity_len;
  logic [LEN_W-1:0]   first_root;
  logic [LEN_W-1:0]   root_step;
  logic [DEPTH_W-1:0] depth;
  logic               dual_basis;

  irs_reg_t reg_idx;
  logic     cfg_wr;
  logic     cfg_hit;

  // effective settings
  logic [LEN_W-1:0]   eff_n;
  logic [PAR_W-1:0]   p_cl;
  logic [PAR_W-1:0]   eff_p;
  logic [LEN_W-1:0]   eff_k;
  logic [DEPTH_W-1:0] eff_d;

  gen_cfg_t gen_cfg;
  logic     gen_busy;
  par_vec_t gen_cf;

  // encoder state
  par_vec_t         rem [MAX_DEPTH];
  logic             draining;
  logic [ROW_W-1:0] row_cnt;
  logic [LEN_W-1:0] col_cnt;

  // input register
  logic v1;
  logic cmd1;
  sym_t sym1;

  logic     move1;
  logic     accept;
  par_vec_t cur_row;
  par_vec_t row_upd;
  sym_t     din;
  sym_t     fb;
  sym_t     par_sym;
  sym_t     par_out;
  logic     phase_err;
  logic     row_wrap;
  logic     blk_end;
  sym_t     res_symbol;
  logic     res_parity;
  logic     res_last;

  // apb decode and read back
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_idx = irs_reg_t'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    cfg_hit = 1'b0;
    prdata  = '0;
    case (reg_idx)
      REG_FIELD_POLY: begin cfg_hit = cfg_wr; prdata = APB_DATA_W'(field_poly); end
      REG_CODE_LEN:   begin cfg_hit = cfg_wr; prdata = APB_DATA_W'(code_len);   end
      REG_PARITY_LEN: begin cfg_hit = cfg_wr; prdata = APB_DATA_W'(parity_len); end
      REG_FIRST_ROOT: begin cfg_hit = cfg_wr; prdata = APB_DATA_W'(first_root); end
      REG_ROOT_STEP:  begin cfg_hit = cfg_wr; prdata = APB_DATA_W'(root_step);  end
      REG_DEPTH:      begin cfg_hit = cfg_wr; prdata = APB_DATA_W'(depth);      end
      REG_DUAL_BASIS: begin cfg_hit = cfg_wr; prdata = APB_DATA_W'(dual_basis); end
      default: begin
        cfg_hit = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      field_poly <= RST_FIELD_POLY;
      code_len   <= RST_CODE_LEN;
      parity_len <= RST_PARITY_LEN;
      first_root <= RST_FIRST_ROOT;
      root_step  <= RST_ROOT_STEP;
      depth      <= RST_DEPTH;
      dual_basis <= RST_DUAL_BASIS;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FIELD_POLY: field_poly <= pwdata[POLY_W-1:0];
        REG_CODE_LEN:   code_len   <= pwdata[LEN_W-1:0];
        REG_PARITY_LEN: parity_len <= pwdata[PAR_W-1:0];
        REG_FIRST_ROOT: first_root <= pwdata[LEN_W-1:0];
        REG_ROOT_STEP:  root_step  <= pwdata[LEN_W-1:0];
        REG_DEPTH:      depth      <= pwdata[DEPTH_W-1:0];
        REG_DUAL_BASIS: dual_basis <= pwdata[0];
        default: ;
      endcase
    end
  end

  // clamp code length, parity length and depth
  always_comb begin
    eff_n = (code_len < LEN_W'(MIN_CODE_LEN)) ? LEN_W'(MIN_CODE_LEN) : code_len;
    if (parity_len < PAR_W'(MIN_PARITY)) begin
      p_cl = PAR_W'(MIN_PARITY);
    end else if (parity_len > PAR_W'(MAX_PARITY)) begin
      p_cl = PAR_W'(MAX_PARITY);
    end else begin
      p_cl = parity_len;
    end
    eff_p = (LEN_W'(p_cl) >= eff_n) ? PAR_W'(eff_n - LEN_W'(1)) : p_cl;
    eff_k = eff_n - LEN_W'(eff_p);
    if (depth == '0) begin
      eff_d = DEPTH_W'(1);
    end else if (depth > DEPTH_W'(MAX_DEPTH)) begin
      eff_d = DEPTH_W'(MAX_DEPTH);
    end else begin
      eff_d = depth;
    end
  end

  // generator polynomial builder
  always_comb begin
    gen_cfg.poly       = field_poly[SYM_BITS-1:0];
    gen_cfg.first_root = first_root;
    gen_cfg.root_step  = root_step;
    gen_cfg.eff_p      = eff_p;
  end

  irs_genpoly u_genpoly (
    .clk    (clk),
    .rst    (rst),
    .start  (cfg_hit),
    .cfg    (gen_cfg),
    .busy   (gen_busy),
    .coeffs (gen_cf)
  );

  // handshake between input register and result register
  assign move1    = v1 & (~out_valid | out_ready);
  assign in_ready = ~gen_busy & ~cfg_wr & (~v1 | move1);
  assign accept   = in_valid & in_ready;

  // lfsr step of the selected row
  always_comb begin
    cur_row = rem[row_cnt];
    din     = dual_basis ? D2C_TAB[sym1] : sym1;
    fb      = din ^ cur_row[0];
    row_upd = cur_row >> SYM_BITS;
    for (int j = 0; j < MAX_PARITY; j++) begin
      row_upd[j] = row_upd[j] ^ gf_mul(gen_cf[j], fb, field_poly[SYM_BITS-1:0]);
    end
  end

  // phase check, block position and result
  always_comb begin
    phase_err = (cmd1 != draining);
    row_wrap  = (DEPTH_W'(row_cnt) == eff_d - DEPTH_W'(1));
    blk_end   = row_wrap & (draining ? (col_cnt == LEN_W'(eff_p) - LEN_W'(1))
                                     : (col_cnt == eff_k - LEN_W'(1)));
    par_sym   = cur_row[col_cnt[OFF_W-1:0]];
    par_out   = dual_basis ? conv_to_dual(par_sym) : par_sym;
    if (phase_err) begin
      res_symbol = '0;
      res_parity = 1'b0;
      res_last   = 1'b0;
    end else if (draining) begin
      res_symbol = par_out;
      res_parity = 1'b1;
      res_last   = blk_end;
    end else begin
      res_symbol = sym1;
      res_parity = 1'b0;
      res_last   = 1'b0;
    end
  end

  // control state and remainders
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
      draining  <= 1'b0;
      row_cnt   <= '0;
      col_cnt   <= '0;
      for (int r = 0; r < MAX_DEPTH; r++) rem[r] <= '0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (move1) begin
        v1 <= 1'b0;
      end

      if (move1) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_hit) begin
        draining <= 1'b0;
        row_cnt  <= '0;
        col_cnt  <= '0;
        for (int r = 0; r < MAX_DEPTH; r++) rem[r] <= '0;
      end else if (move1 && !phase_err) begin
        if (blk_end) begin
          row_cnt <= '0;
          col_cnt <= '0;
        end else if (row_wrap) begin
          row_cnt <= '0;
          col_cnt <= col_cnt + LEN_W'(1);
        end else begin
          row_cnt <= row_cnt + ROW_W'(1);
        end

        if (!draining) begin
          rem[row_cnt] <= row_upd;
          if (blk_end) draining <= 1'b1;
        end else if (blk_end) begin
          draining <= 1'b0;
          for (int r = 0; r < MAX_DEPTH; r++) rem[r] <= '0;
        end
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd1 <= cmd;
      sym1 <= symbol;
    end
    if (move1) begin
      out_symbol <= res_symbol;
      is_parity  <= res_parity;
      last       <= res_last;
      error      <= phase_err;
    end
  end

  // checks
  a_last_is_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> is_parity && !error)
    else $error("last flag on a result that is not parity");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> out_symbol == '0 && !is_parity && !last)
    else $error("error result carries data");

  a_block_wrap: assert property (@(posedge clk) disable iff (rst)
    move1 && draining && !phase_err && blk_end && !cfg_hit |=>
      !draining && row_cnt == '0 && col_cnt == '0)
    else $error("block did not restart after final parity");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    DEPTH_W'(row_cnt) < eff_d)
    else $error("row counter beyond interleave depth");

endmodule

// File: hdl/irs_genpoly.sv
`timescale 1ns / 1ps
// generator polynomial builder: one root per pass, root power by square-and-multiply
// depends on irs_pkg

module irs_genpoly (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  irs_pkg::gen_cfg_t  cfg,
  output logic               busy,
  output irs_pkg::par_vec_t  coeffs
);
  import irs_pkg::*;

  gen_state_t       state, state_next;
  sym_t             expo;
  sym_t             pw;
  logic [BIT_W-1:0] bitn;
  logic [PAR_W-1:0] nroot;
  par_vec_t         cf;

  logic [2*SYM_BITS-1:0] prod;
  logic [SYM_BITS:0]     fold1;
  sym_t                  fold2;
  sym_t                  expo0;
  logic [SYM_BITS:0]     esum;
  sym_t                  expo_inc;
  sym_t                  sq;
  sym_t                  pw_next;
  par_vec_t              cf_next;
  logic                  root_last;

  // first root exponent: (root_step * first_root) mod 255 by byte folding
  always_comb begin
    prod  = (2*SYM_BITS)'(cfg.root_step) * (2*SYM_BITS)'(cfg.first_root);
    fold1 = (SYM_BITS+1)'(prod[2*SYM_BITS-1:SYM_BITS]) + (SYM_BITS+1)'(prod[SYM_BITS-1:0]);
    fold2 = fold1[SYM_BITS-1:0] + sym_t'(fold1[SYM_BITS]);
    expo0 = (fold2 == sym_t'(GF_ORDER)) ? '0 : fold2;
  end

  // next root exponent, one compare and subtract
  always_comb begin
    esum     = (SYM_BITS+1)'(expo) + (SYM_BITS+1)'(cfg.root_step);
    expo_inc = (esum >= (SYM_BITS+1)'(GF_ORDER)) ?
               sym_t'(esum - (SYM_BITS+1)'(GF_ORDER)) : esum[SYM_BITS-1:0];
  end

  // one square-and-multiply step, exponent msb first
  always_comb begin
    sq      = gf_mul(pw, pw, cfg.poly);
    pw_next = expo[bitn] ? gf_mul(sq, ALPHA, cfg.poly) : sq;
  end

  // multiply the polynomial by (x + root), all coefficients at once
  always_comb begin
    cf_next[0] = cf[0] ^ pw;
    for (int i = 1; i < MAX_PARITY; i++) begin
      cf_next[i] = cf[i] ^ gf_mul(pw, cf[i-1], cfg.poly);
    end
  end

  assign root_last = (nroot == cfg.eff_p - PAR_W'(1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      GEN_IDLE: state_next = GEN_IDLE;
      GEN_MUL:  state_next = GEN_POW;
      GEN_POW:  if (bitn == '0) state_next = GEN_ACC;
      GEN_ACC:  state_next = root_last ? GEN_IDLE : GEN_POW;
      default:  state_next = GEN_IDLE;
    endcase
    if (start) state_next = GEN_MUL;
  end

  // outputs
  always_comb begin
    busy   = (state != GEN_IDLE);
    coeffs = cf;
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GEN_MUL;
      bitn  <= BIT_W'(SYM_BITS - 1);
      nroot <= '0;
    end else begin
      state <= state_next;
      case (state)
        GEN_MUL: begin
          bitn  <= BIT_W'(SYM_BITS - 1);
          nroot <= '0;
        end
        GEN_POW: bitn <= bitn - BIT_W'(1);
        GEN_ACC: begin
          bitn  <= BIT_W'(SYM_BITS - 1);
          nroot <= nroot + PAR_W'(1);
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      GEN_MUL: begin
        expo <= expo0;
        pw   <= sym_t'(1);
        cf   <= '0;
      end
      GEN_POW: pw <= pw_next;
      GEN_ACC: begin
        cf   <= cf_next;
        expo <= expo_inc;
        pw   <= sym_t'(1);
      end
      default: ;
    endcase
  end

endmodule
